[rtl/fvwr_pkg.sv]
// fvwr_pkg: shared constants, widths and a helper function for the
// first-vertex-within-radius search block; no dependencies
`default_nettype none

package fvwr_pkg;

   // default sizing
   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_WIDTH_DEF  = 32;

   // fixed field widths
   localparam int INDEX_W   = 10;   // vertex_index and match_index
   localparam int COUNT_W   = 11;   // vertex_count register
   localparam int RADIUS_W  = 31;   // radius register
   localparam int R2_W      = 2 * RADIUS_W;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = RADIUS_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 1'b1;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // address width of a store of the given depth
   function automatic int addr_w(input int depth);
      int w;
      w = 1;
      if (depth > 1) begin
         w = $clog2(depth);
      end
      return w;
   endfunction

   // control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

`default_nettype wire

[rtl/fvwr_store.sv]
// fvwr_store: vertex memory, one write port and one read port with
// registered read data; uses fvwr_pkg
`default_nettype none

module fvwr_store
   import fvwr_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [addr_w(MAX_VERTICES)-1:0]     wr_addr,
   input  wire logic [3*COORD_WIDTH-1:0]            wr_data,
   input  wire logic [addr_w(MAX_VERTICES)-1:0]     rd_addr,
   output      logic [3*COORD_WIDTH-1:0]            rd_data
);

   localparam int AW = addr_w(MAX_VERTICES);

   logic [3*COORD_WIDTH-1:0] mem_ff [MAX_VERTICES];
   logic [3*COORD_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data always registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/fvwr_dist.sv]
// fvwr_dist: pipelined squared-distance test of one stored vertex against
// the query point; uses fvwr_pkg
`default_nettype none

module fvwr_dist
   import fvwr_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              flush,
   input  wire logic [RADIUS_W-1:0]               radius,
   input  wire logic [COORD_WIDTH-1:0]            point_x,
   input  wire logic [COORD_WIDTH-1:0]            point_y,
   input  wire logic [COORD_WIDTH-1:0]            point_z,
   input  wire logic                              in_valid,
   input  wire logic [addr_w(MAX_VERTICES)-1:0]   in_idx,
   input  wire logic [3*COORD_WIDTH-1:0]          vertex,
   output      logic                              out_valid,
   output      logic                              out_hit,
   output      logic [addr_w(MAX_VERTICES)-1:0]   out_idx
);

   localparam int CW    = COORD_WIDTH;
   localparam int AW    = addr_w(MAX_VERTICES);
   localparam int SQ_W  = 2 * CW + 2;
   localparam int SUM_W = 2 * CW + 4;
   localparam int CMP_W = (SUM_W > R2_W) ? SUM_W : R2_W;

   // |a - b| of two signed values, exact in CW+1 bits
   function automatic logic [CW:0] abs_diff(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
      logic [CW:0] d;
      d = {a[CW-1], a} - {b[CW-1], b};
      if (d[CW]) begin
         d = ~d + {{CW{1'b0}}, 1'b1};
      end
      return d;
   endfunction

   logic [R2_W-1:0]  r2_ff;
   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   logic             v1_in, v2_in, v3_in, v4_in;
   logic [AW-1:0]    i1_ff, i2_ff, i3_ff, i4_ff;
   logic [CW:0]      ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0]  sx_ff, sy_ff, sz_ff;
   logic [SUM_W-1:0] sum_ff;
   logic             hit_ff;

   // radius squared, registered from the radius register
   always_ff @(posedge clock) begin
      r2_ff <= R2_W'(radius) * R2_W'(radius);
   end

   always_comb begin
      v1_in = in_valid & ~flush;
      v2_in = v1_ff & ~flush;
      v3_in = v2_ff & ~flush;
      v4_in = v3_ff & ~flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      // absolute differences
      ax_ff  <= abs_diff(point_x, vertex[CW-1:0]);
      ay_ff  <= abs_diff(point_y, vertex[2*CW-1:CW]);
      az_ff  <= abs_diff(point_z, vertex[3*CW-1:2*CW]);
      i1_ff  <= in_idx;
      // squares
      sx_ff  <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
      sy_ff  <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
      sz_ff  <= SQ_W'(az_ff) * SQ_W'(az_ff);
      i2_ff  <= i1_ff;
      // sum
      sum_ff <= SUM_W'(sx_ff) + SUM_W'(sy_ff) + SUM_W'(sz_ff);
      i3_ff  <= i2_ff;
      // strict compare
      hit_ff <= CMP_W'(sum_ff) < CMP_W'(r2_ff);
      i4_ff  <= i3_ff;
   end

   assign out_valid = v4_ff;
   assign out_hit   = hit_ff;
   assign out_idx   = i4_ff;

endmodule

`default_nettype wire

[rtl/first_vertex_within_radius.sv]
// first_vertex_within_radius: top level, register file, scan sequencer and
// result register; uses fvwr_pkg, fvwr_store and fvwr_dist
`default_nettype none

// channel   dir  handshake              word
// req_      in   req_valid/req_ready    kind, vertex_index, pos_x, pos_y, pos_z
// rsp_      out  rsp_valid/rsp_ready    found, match_index
// csr_      in   csr_valid/csr_ready    index, wdata (always ready)
//
// a vertex write leaves no word on rsp_; a query scans entries from 0
// through one memory read port, one entry per cycle, and stops at the first
// hit; entries pass the registered read, then the difference, square, sum
// and compare stages; a zero count goes straight to the done state
// req_ready is high only between queries; a finished query waits in the done
// state while a stalled rsp_ holds the response register; no req_ word is taken meanwhile
// synchronous reset clears registers and control; vertex memory is not
// cleared and an entry reads as garbage until written

module first_vertex_within_radius
   import fvwr_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request words
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic                   req_kind,
   input  wire logic [INDEX_W-1:0]     req_vertex_index,
   input  wire logic signed [31:0]     req_pos_x,
   input  wire logic signed [31:0]     req_pos_y,
   input  wire logic signed [31:0]     req_pos_z,
   // response words
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_found,
   output      logic [INDEX_W-1:0]     rsp_match_index,
   // register writes
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW    = COORD_WIDTH;
   localparam int AW    = addr_w(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   // configuration registers
   logic [COUNT_W-1:0]  vertex_count_ff, vertex_count_in;
   logic [RADIUS_W-1:0] radius_ff, radius_in;

   // sequencer
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;      // entries to search
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;    // next entry to read
   logic                rd_v_ff, rd_v_in;        // read in flight, aligned to data
   logic [AW-1:0]       rd_a_ff;
   logic [CW-1:0]       px_ff, py_ff, pz_ff;
   logic                found_ff, found_in;
   logic [INDEX_W-1:0]  midx_ff, midx_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;

   // datapath links
   logic                req_acc;
   logic                mem_wr;
   logic [AW-1:0]       rd_addr;
   logic                issue;
   logic                finish;
   logic                flush;
   logic [CNT_W-1:0]    count_sat;
   logic [3*CW-1:0]     rd_data;
   logic                d_valid, d_hit;
   logic [AW-1:0]       d_idx;
   logic                d_last;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid & req_ready;

   // register writes; an index outside the list does nothing
   always_comb begin
      vertex_count_in = vertex_count_ff;
      radius_in       = radius_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_in = csr_wdata[COUNT_W-1:0];
            CSR_RADIUS:       radius_in       = csr_wdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // writes beyond the store are dropped
   assign mem_wr = req_acc & (req_kind == KIND_WRITE)
                 & (32'(req_vertex_index) < 32'(MAX_VERTICES));

   // search length, saturated to the store depth
   assign count_sat = (32'(vertex_count_ff) > 32'(MAX_VERTICES)) ?
                      CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count_ff);

   // one read per cycle while entries remain
   assign issue   = (state_ff == ST_SCAN) & (rd_idx_ff < count_ff);
   assign rd_addr = rd_idx_ff[AW-1:0];

   // last entry reached without a hit, or a hit
   assign d_last = (CNT_W'(d_idx) == (count_ff - CNT_W'(1)));
   assign finish = (state_ff == ST_SCAN) & d_valid & (d_hit | d_last);
   // later reads still in the pipe are dropped once the answer is known
   assign flush  = finish;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      rd_v_in      = issue & ~flush;
      found_in     = found_ff;
      midx_in      = midx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_idx_in   = rsp_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_kind == KIND_QUERY)) begin
               count_in  = count_sat;
               rd_idx_in = '0;
               if (count_sat == '0) begin
                  found_in = 1'b0;
                  midx_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (finish) begin
               found_in = d_hit;
               midx_in  = d_hit ? INDEX_W'(d_idx) : '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_idx_in   = midx_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
         radius_ff       <= '0;
         state_ff        <= ST_IDLE;
         rd_v_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         radius_ff       <= radius_in;
         state_ff        <= state_in;
         rd_v_ff         <= rd_v_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      rd_idx_ff    <= rd_idx_in;
      rd_a_ff      <= rd_addr;
      found_ff     <= found_in;
      midx_ff      <= midx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
      if (req_acc && (req_kind == KIND_QUERY)) begin
         px_ff <= req_pos_x[CW-1:0];
         py_ff <= req_pos_y[CW-1:0];
         pz_ff <= req_pos_z[CW-1:0];
      end
   end

   fvwr_store #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (AW'(req_vertex_index)),
      .wr_data ({req_pos_z[CW-1:0], req_pos_y[CW-1:0], req_pos_x[CW-1:0]}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fvwr_dist #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .flush     (flush),
      .radius    (radius_ff),
      .point_x   (px_ff),
      .point_y   (py_ff),
      .point_z   (pz_ff),
      .in_valid  (rd_v_ff),
      .in_idx    (rd_a_ff),
      .vertex    (rd_data),
      .out_valid (d_valid),
      .out_hit   (d_hit),
      .out_idx   (d_idx)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_idx_ff;

endmodule

`default_nettype wire

[bench/testbench.sv]
// testbench for first_vertex_within_radius: a vertex store with a linear
// search for the first entry within a radius, checked against a predictor
// depends on fvwr_pkg and the first_vertex_within_radius top level only

module testbench;
   import fvwr_pkg::*;

   localparam int          MAX_ENTRIES     = MAX_VERTICES_DEF;
   localparam int unsigned RADIUS_MAX      = 32'h7FFF_FFFF;
   localparam logic [31:0] COORD_MIN       = 32'h8000_0000;
   localparam logic [31:0] COORD_MAX       = 32'h7FFF_FFFF;
   localparam logic [31:0] COORD_ONE       = 32'h0001_0000;   // 1.0 in q16.16
   localparam int          RANDOM_PHASES   = 12;
   localparam int          PHASE_WORDS     = 45;
   localparam int          HOLD_OFF_CYCLES = 500;
   localparam int          CYCLE_LIMIT     = 2_000_000;

   // one expected answer on rsp_
   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_index;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_kind         = KIND_WRITE;
   logic [INDEX_W-1:0]    req_vertex_index = '0;
   logic signed [31:0]    req_pos_x        = '0;
   logic signed [31:0]    req_pos_y        = '0;
   logic signed [31:0]    req_pos_z        = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic                  rsp_found;
   logic [INDEX_W-1:0]    rsp_match_index;
   logic                  csr_valid        = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index        = CSR_VERTEX_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   // calm: no idling on either side; hold_off_request: long rsp_ stall
   bit          calm             = 1'b0;
   bit          hold_off_request = 1'b0;
   bit          hold_off_done    = 1'b0;
   int unsigned sink_wait        = 0;
   int unsigned cycle_count      = 0;
   int unsigned settings_done    = 0;

   first_vertex_within_radius dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_index  (rsp_match_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // squared distance along one axis, exact: |a-b| < 2^32 so the square fits
   function automatic logic [67:0] axis_sq(input logic [31:0] a, input logic [31:0] b);
      logic signed [33:0] d;
      logic [33:0]        mag;
      d   = $signed({{2{a[31]}}, a}) - $signed({{2{b[31]}}, b});
      mag = d[33] ? 34'(-d) : 34'(d);
      return 68'(mag) * 68'(mag);
   endfunction

   // predictor: own copy of the vertex store and registers, queue of answers
   class answer_board_type;
      logic [31:0]         vx [MAX_ENTRIES];
      logic [31:0]         vy [MAX_ENTRIES];
      logic [31:0]         vz [MAX_ENTRIES];
      bit                  written [MAX_ENTRIES];
      logic [COUNT_W-1:0]  count_reg  = '0;
      logic [RADIUS_W-1:0] radius_reg = '0;
      answer_type          pending_answers [$];
      int unsigned         failures = 0;
      int unsigned         writes   = 0;
      int unsigned         queries  = 0;
      int unsigned         hits     = 0;

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_VERTEX_COUNT) begin
            count_reg = data[COUNT_W-1:0];
         end else if (idx == CSR_RADIUS) begin
            radius_reg = data[RADIUS_W-1:0];
         end
      endfunction

      // entries 0 .. n-1 all written since reset
      function int unsigned written_prefix();
         int unsigned n;
         n = 0;
         while (n < MAX_ENTRIES && written[n]) n++;
         return n;
      endfunction

      // first entry within the radius, count saturated at the store size
      function answer_type first_hit(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
         answer_type  ans;
         int unsigned span;
         logic [67:0] limit;
         logic [67:0] sq_sum;
         ans   = '0;
         span  = (count_reg > MAX_ENTRIES) ? MAX_ENTRIES : count_reg;
         limit = 68'(radius_reg) * 68'(radius_reg);
         for (int unsigned e = 0; e < span; e++) begin
            sq_sum = axis_sq(px, vx[e]) + axis_sq(py, vy[e]) + axis_sq(pz, vz[e]);
            if (sq_sum < limit) begin
               ans.found       = 1'b1;
               ans.match_index = INDEX_W'(e);
               return ans;
            end
         end
         return ans;
      endfunction

      function void take_word(logic kind, logic [INDEX_W-1:0] slot,
                              logic [31:0] x, logic [31:0] y, logic [31:0] z);
         answer_type ans;
         if (kind == KIND_WRITE) begin
            vx[slot]      = x;
            vy[slot]      = y;
            vz[slot]      = z;
            written[slot] = 1'b1;
            writes++;
         end else begin
            ans = first_hit(x, y, z);
            pending_answers = {pending_answers, ans};
            queries++;
            if (ans.found) hits++;
         end
      endfunction

      function void check_answer(logic found, logic [INDEX_W-1:0] match_index);
         answer_type want;
         if (pending_answers.size() == 0) begin
            $error("answer with none pending: found %0b match_index %0d", found, match_index);
            failures++;
            return;
         end
         want = pending_answers.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0b actual %0b", want.found, found);
            failures++;
         end
         if (match_index !== want.match_index) begin
            $error("match_index: expected %0d actual %0d", want.match_index, match_index);
            failures++;
         end
      endfunction
   endclass

   answer_board_type board = new();

   // clock and run limit
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** first_vertex_within_radius: FAILED **");
         $finish;
      end
   end

   // rsp_ side: check every accepted word, stall at random, and hold off
   // for a long stretch once on request so the block backs up into req_
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready     <= 1'b0;
         sink_wait     <= 0;
         hold_off_done <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_answer(rsp_found, rsp_match_index);
         if (hold_off_request && !hold_off_done) begin
            hold_off_done <= 1'b1;
            rsp_ready     <= 1'b0;
            sink_wait     <= HOLD_OFF_CYCLES;
         end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
         end else if (!calm && $urandom_range(0, 99) < 12) begin
            rsp_ready <= 1'b0;
            sink_wait <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                       : $urandom_range(15, 60);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // idle cycles before a req_ word: mostly none, some short, a few long
   function automatic int unsigned sender_gap();
      int unsigned roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   // coordinate mix: extremes, a small cluster around the origin, full range
   function automatic logic [31:0] pick_coord();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return COORD_MIN;
      if (roll < 8) return COORD_MAX;
      if (roll < 11) return 32'h0;
      if (roll < 13) return 32'hFFFF_FFFF;
      if (roll < 45) return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
      return $urandom;
   endfunction

   // random offset in [-span, span], wraps like the 32-bit field
   function automatic logic [31:0] jitter(input int unsigned span);
      logic [31:0] v;
      v = $urandom_range(0, span);
      return $urandom_range(0, 1) ? v : -v;
   endfunction

   // one req_ word; valid stays high across back-to-back words
   task automatic send_word(input logic kind, input logic [INDEX_W-1:0] slot,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
      int unsigned gap;
      gap = sender_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_vertex_index <= slot;
      req_pos_x        <= x;
      req_pos_y        <= y;
      req_pos_z        <= z;
      do @(posedge clock); while (!req_ready);
      board.take_word(kind, slot, x, y, z);
   endtask

   // both registers, back to back on csr_
   task automatic configure(input int unsigned count, input int unsigned rad);
      csr_valid <= 1'b1;
      csr_index <= CSR_VERTEX_COUNT;
      csr_wdata <= CSR_DATA_W'(count);
      do @(posedge clock); while (!csr_ready);
      board.set_register(CSR_VERTEX_COUNT, CSR_DATA_W'(count));
      csr_index <= CSR_RADIUS;
      csr_wdata <= CSR_DATA_W'(rad);
      do @(posedge clock); while (!csr_ready);
      board.set_register(CSR_RADIUS, CSR_DATA_W'(rad));
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // stop offering, wait for every answer, then let the block go quiet
   task automatic settle(input int unsigned tail);
      req_valid <= 1'b0;
      while (board.pending_answers.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // query exactly at a stored vertex
   task automatic query_entry(input int unsigned e);
      send_word(KIND_QUERY, INDEX_W'($urandom_range(0, MAX_ENTRIES - 1)),
                board.vx[e], board.vy[e], board.vz[e]);
   endtask

   // write growing the written prefix, refreshing it, or anywhere in the store;
   // some copies of existing vertices so several entries can match
   task automatic random_write();
      int unsigned prefix, slot, src;
      logic [31:0] x, y, z;
      prefix = board.written_prefix();
      if ($urandom_range(0, 99) < 40 && prefix < MAX_ENTRIES) begin
         slot = prefix;
      end else if ($urandom_range(0, 99) < 60) begin
         slot = $urandom_range(0, (prefix < MAX_ENTRIES) ? prefix : MAX_ENTRIES - 1);
      end else begin
         slot = $urandom_range(0, MAX_ENTRIES - 1);
      end
      if (prefix != 0 && $urandom_range(0, 99) < 20) begin
         src = $urandom_range(0, prefix - 1);
         x   = board.vx[src] + jitter(64);
         y   = board.vy[src] + jitter(64);
         z   = board.vz[src] + jitter(64);
      end else begin
         x = pick_coord();
         y = pick_coord();
         z = pick_coord();
      end
      send_word(KIND_WRITE, INDEX_W'(slot), x, y, z);
   endtask

   // query aimed at a searched vertex: exact, on or just inside the radius,
   // well inside, or scattered around; some points anywhere
   task automatic random_query();
      int unsigned span, roll, target, rad, axis;
      logic [31:0] q [3];
      logic [31:0] shift;
      span = (board.count_reg > MAX_ENTRIES) ? MAX_ENTRIES : board.count_reg;
      rad  = board.radius_reg;
      roll = $urandom_range(0, 99);
      if (span == 0 || roll < 15) begin
         q[0] = pick_coord();
         q[1] = pick_coord();
         q[2] = pick_coord();
      end else begin
         target = $urandom_range(0, span - 1);
         q[0]   = board.vx[target];
         q[1]   = board.vy[target];
         q[2]   = board.vz[target];
         if (roll < 40) begin
            // exact point
         end else if (roll < 65) begin
            // boundary: exactly at the radius (no match) or one lsb inside
            axis    = $urandom_range(0, 2);
            shift   = (rad == 0) ? 32'h0 : rad - $urandom_range(0, 1);
            q[axis] = $urandom_range(0, 1) ? q[axis] + shift : q[axis] - shift;
         end else if (roll < 85) begin
            for (int a = 0; a < 3; a++) q[a] = q[a] + jitter(rad / 2);
         end else begin
            for (int a = 0; a < 3; a++) q[a] = q[a] + jitter(rad * 2);
         end
      end
      send_word(KIND_QUERY, INDEX_W'($urandom_range(0, MAX_ENTRIES - 1)), q[0], q[1], q[2]);
   endtask

   initial begin : stimulus
      int unsigned prefix, cnt, rad;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty search, extreme vertices, zero radius, strict edge,
      // widest differences, lowest index among several matches
      calm = 1'b1;
      configure(0, RADIUS_MAX);
      send_word(KIND_QUERY, '0, 32'h0, 32'h0, 32'h0);
      send_word(KIND_WRITE, 10'd0, COORD_MIN, COORD_MIN, COORD_MIN);
      send_word(KIND_WRITE, 10'd1, COORD_MAX, COORD_MAX, COORD_MAX);
      send_word(KIND_WRITE, 10'd2, 32'h0, 32'h0, 32'h0);
      send_word(KIND_WRITE, 10'd3, COORD_ONE, 32'h0, 32'h0);
      send_word(KIND_WRITE, 10'd4, 32'h0, COORD_ONE, -COORD_ONE);
      send_word(KIND_WRITE, 10'd5, 32'h0, 32'h0, 32'h0);
      send_word(KIND_WRITE, 10'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(KIND_WRITE, 10'd7, COORD_MIN, COORD_MAX, 32'h0);
      settle(16);
      configure(8, 0);
      send_word(KIND_QUERY, 10'h3FF, 32'h0, 32'h0, 32'h0);      // zero radius
      settle(16);
      configure(8, COORD_ONE);
      send_word(KIND_QUERY, '0, 32'h0, 32'h0, 32'h0);           // entries 2, 5 and 6 match
      send_word(KIND_QUERY, '0, 2 * COORD_ONE, 32'h0, 32'h0);   // on the radius: none
      send_word(KIND_QUERY, '0, 2 * COORD_ONE - 1, 32'h0, 32'h0);
      settle(16);
      configure(8, RADIUS_MAX);
      send_word(KIND_QUERY, '0, COORD_MAX, COORD_MAX, COORD_MAX);
      send_word(KIND_QUERY, '0, COORD_MIN, COORD_MAX, 32'h0);
      settle(16);
      configure(1, RADIUS_MAX);
      send_word(KIND_QUERY, '0, COORD_MIN, COORD_MIN, COORD_MIN);

      // random phases, new settings at each quiet point
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle(16);
         prefix = board.written_prefix();
         case (p % 4)
            0: cnt = prefix;
            1: cnt = $urandom_range(0, prefix);
            2: cnt = (prefix < 4) ? prefix : $urandom_range(1, 4);
            default: cnt = $urandom_range(prefix / 2, prefix);
         endcase
         case (p % 6)
            0: rad = $urandom_range(1, 32'h10_0000);
            1: rad = RADIUS_MAX;
            2: rad = $urandom_range(0, RADIUS_MAX);
            3: rad = $urandom_range(1, 32'h400_0000);
            4: rad = 0;
            default: rad = 1;
         endcase
         calm = (p == 0 || p == 7);
         configure(cnt, rad);
         // long rsp_ stall while req_ keeps offering
         if (p == 5) hold_off_request <= 1'b1;
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if ($urandom_range(0, 99) < 45) random_query();
            else random_write();
         end
      end

      // scans over the whole written prefix, then a count above capacity
      // with queries sure to hit inside the written entries
      settle(16);
      prefix = board.written_prefix();
      calm   = 1'b0;
      configure(prefix, $urandom_range(1, 32'h10_0000));
      query_entry(prefix - 1);
      for (int k = 0; k < 4; k++) query_entry($urandom_range(prefix / 2, prefix - 1));
      random_query();
      random_query();
      settle(16);
      configure(2047, RADIUS_MAX);
      query_entry(prefix - 1);
      query_entry($urandom_range(0, prefix - 1));

      settle(64);
      $display("covered %0d vertex writes and %0d queries, %0d of them hits",
               board.writes, board.queries, board.hits);
      $display("%0d register settings, counts 0 to 2047, radius 0 to full scale",
               settings_done);
      if (board.failures == 0 && board.pending_answers.size() == 0) begin
         $display("** first_vertex_within_radius: PASSED **");
      end else begin
         $display("** first_vertex_within_radius: FAILED **");
      end
      $finish;
   end

endmodule
